/* rtl/core/fmv_pkg.sv */
`default_nettype none

package fmv_pkg;

	// Field widths
	localparam int COUNT_BITS    = 16;
	localparam int FRACTION_BITS = 8;
	localparam int SAMPLE_W      = 16;
	localparam int MEAN_W        = 24;
	localparam int VAR_W         = 38;

	// Accumulator and work widths
	localparam int SUM_W  = SAMPLE_W + COUNT_BITS;
	localparam int SQ_W   = 2 * SAMPLE_W + COUNT_BITS;
	localparam int PROD_W = COUNT_BITS + SQ_W;
	localparam int DEN_W  = 2 * COUNT_BITS;
	localparam int DIV_W  = PROD_W + FRACTION_BITS;
	localparam int STEP_W = $clog2(DIV_W);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} sample_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean_q8;
		logic [VAR_W-1:0]         variance_q8;
		logic [COUNT_BITS-1:0]    frame_count;
		logic                     overflow;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/frame_mean_variance_top.sv */
// Channel   Direction  Handshake                      Payload
// sample    in         sample_valid / sample_stall    fmv_pkg::sample_t
// result    out        result_valid / result_stall    fmv_pkg::result_t
//
// Samples with last low are accepted at one per cycle while the block is accumulating.
// A sample with last high starts the frame-end computation on one shared
// 65-bit add/subtract unit, during which sample_stall is high.
// The result waits in an output register, so a stalled result only holds
// the block once the next frame has finished too. Reset clears all frame sums.
`default_nettype none

module frame_mean_variance_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  fmv_pkg::sample_t sample_data,
	output logic             result_valid,
	input  logic             result_stall,
	output fmv_pkg::result_t result_data
);

	typedef enum logic [7:0] {
		ST_ACC  = 8'b0000_0001,
		ST_PREP = 8'b0000_0010,
		ST_DIVM = 8'b0000_0100,
		ST_NN   = 8'b0000_1000,
		ST_NQ   = 8'b0001_0000,
		ST_SS   = 8'b0010_0000,
		ST_DIVV = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Frame accumulators
	logic [fmv_pkg::COUNT_BITS-1:0]   cnt_q;
	logic signed [fmv_pkg::SUM_W-1:0] sum_q;
	logic [fmv_pkg::SQ_W-1:0]         sq_q;
	logic                             ovf_q;

	// Work registers of the shared unit
	logic [fmv_pkg::DIV_W-1:0]  acc_q;
	logic [fmv_pkg::DEN_W-1:0]  rem_q;
	logic [fmv_pkg::DEN_W-1:0]  den_q;
	logic [fmv_pkg::PROD_W-1:0] mcand_q;
	logic [fmv_pkg::SUM_W-1:0]  mplier_q;
	logic [fmv_pkg::STEP_W-1:0] step_q;
	logic                       neg_q;
	logic [fmv_pkg::MEAN_W-1:0] mean_q;

	logic             result_valid_q;
	fmv_pkg::result_t res_q;

	logic sample_xfer;
	logic out_free;

	logic signed [2*fmv_pkg::SAMPLE_W-1:0] sample_sq;
	logic [fmv_pkg::SUM_W-1:0]             sample_ext;
	logic [fmv_pkg::SUM_W-1:0]             abs_sum;

	logic [fmv_pkg::PROD_W:0]   alu_a;
	logic [fmv_pkg::PROD_W:0]   alu_b;
	logic [fmv_pkg::PROD_W:0]   alu_res;
	logic                       alu_sub;
	logic [fmv_pkg::DEN_W:0]    rem_sh;
	logic                       div_fit;
	logic [fmv_pkg::DEN_W-1:0]  rem_next;
	logic [fmv_pkg::DIV_W-1:0]  quo_next;
	logic [fmv_pkg::PROD_W-1:0] mul_next;
	logic [fmv_pkg::MEAN_W-1:0] mean_mag;
	logic [fmv_pkg::MEAN_W-1:0] mean_val;

	assign sample_stall = (state_q != ST_ACC);
	assign sample_xfer  = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result_data  = res_q;

	// Per-sample terms
	assign sample_sq  = sample_data.sample * sample_data.sample;
	assign sample_ext = {{(fmv_pkg::SUM_W - fmv_pkg::SAMPLE_W){sample_data.sample[fmv_pkg::SAMPLE_W-1]}},
		sample_data.sample};
	assign abs_sum    = sum_q[fmv_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	// Shared add/subtract unit: shift-add multiply steps and restoring divide steps
	assign rem_sh = {rem_q, acc_q[fmv_pkg::DIV_W-1]};

	always_comb begin
		alu_a   = {1'b0, acc_q[fmv_pkg::PROD_W-1:0]};
		alu_b   = mplier_q[0] ? {1'b0, mcand_q} : '0;
		alu_sub = (state_q == ST_SS);
		if (state_q == ST_DIVM || state_q == ST_DIVV) begin
			alu_a   = {{(fmv_pkg::PROD_W - fmv_pkg::DEN_W){1'b0}}, rem_sh};
			alu_b   = {{(fmv_pkg::PROD_W + 1 - fmv_pkg::DEN_W){1'b0}}, den_q};
			alu_sub = 1'b1;
		end
	end

	assign alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	assign mul_next = alu_res[fmv_pkg::PROD_W-1:0];
	assign div_fit  = !alu_res[fmv_pkg::PROD_W];
	assign rem_next = div_fit ? alu_res[fmv_pkg::DEN_W-1:0] : rem_sh[fmv_pkg::DEN_W-1:0];
	assign quo_next = {acc_q[fmv_pkg::DIV_W-2:0], div_fit};

	// Floor the mean: a negative sum with a remainder rounds one step further down
	assign mean_mag = quo_next[fmv_pkg::MEAN_W-1:0]
		+ fmv_pkg::MEAN_W'(neg_q && (rem_next != '0));
	assign mean_val = neg_q ? (~mean_mag + 1'b1) : mean_mag;

	// Sequencer, frame accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_ACC;
			cnt_q          <= '0;
			sum_q          <= '0;
			sq_q           <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// Raise the result on hand-over, drop it after its transfer
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					if (sample_xfer) begin
						if (cnt_q != fmv_pkg::COUNT_MAX) begin
							cnt_q <= cnt_q + 1'b1;
							sum_q <= sum_q + sample_ext;
							sq_q  <= sq_q + {{(fmv_pkg::SQ_W - 2*fmv_pkg::SAMPLE_W){1'b0}},
								sample_sq};
						end else begin
							ovf_q <= 1'b1;
						end
						if (sample_data.last) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: state_q <= ST_DIVM;
				ST_DIVM: if (step_q == '0) state_q <= ST_NN;
				ST_NN:   if (step_q == '0) state_q <= ST_NQ;
				ST_NQ:   if (step_q == '0) state_q <= ST_SS;
				ST_SS:   if (step_q == '0) state_q <= ST_DIVV;
				ST_DIVV: if (step_q == '0) state_q <= ST_DONE;
				ST_DONE: begin
					// Hand over once the output register is free, then clear the frame
					if (out_free) begin
						cnt_q   <= '0;
						sum_q   <= '0;
						sq_q    <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	// Work registers of the shared unit
	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				// Mean: divide |S| * 2^F by n
				acc_q  <= {{(fmv_pkg::DIV_W - fmv_pkg::SUM_W - fmv_pkg::FRACTION_BITS){1'b0}},
					abs_sum, {fmv_pkg::FRACTION_BITS{1'b0}}};
				rem_q  <= '0;
				den_q  <= {{(fmv_pkg::DEN_W - fmv_pkg::COUNT_BITS){1'b0}}, cnt_q};
				neg_q  <= sum_q[fmv_pkg::SUM_W-1];
				step_q <= fmv_pkg::STEP_W'(fmv_pkg::DIV_W - 1);
			end
			ST_DIVM: begin
				rem_q <= rem_next;
				if (step_q == '0) begin
					// Keep the mean, then form n*n
					mean_q   <= mean_val;
					acc_q    <= '0;
					mcand_q  <= {{(fmv_pkg::PROD_W - fmv_pkg::COUNT_BITS){1'b0}}, cnt_q};
					mplier_q <= {{(fmv_pkg::SUM_W - fmv_pkg::COUNT_BITS){1'b0}}, cnt_q};
					step_q   <= fmv_pkg::STEP_W'(fmv_pkg::COUNT_BITS - 1);
				end else begin
					acc_q  <= quo_next;
					step_q <= step_q - 1'b1;
				end
			end
			ST_NN, ST_NQ, ST_SS: begin
				if (step_q != '0) begin
					acc_q    <= {{(fmv_pkg::DIV_W - fmv_pkg::PROD_W){1'b0}}, mul_next};
					mcand_q  <= {mcand_q[fmv_pkg::PROD_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[fmv_pkg::SUM_W-1:1]};
					step_q   <= step_q - 1'b1;
				end else if (state_q == ST_NN) begin
					// Divisor n*n saved, then accumulate n*Q
					den_q    <= mul_next[fmv_pkg::DEN_W-1:0];
					acc_q    <= '0;
					mcand_q  <= {{(fmv_pkg::PROD_W - fmv_pkg::SQ_W){1'b0}}, sq_q};
					mplier_q <= {{(fmv_pkg::SUM_W - fmv_pkg::COUNT_BITS){1'b0}}, cnt_q};
					step_q   <= fmv_pkg::STEP_W'(fmv_pkg::COUNT_BITS - 1);
				end else if (state_q == ST_NQ) begin
					// Subtract S*S from n*Q
					acc_q    <= {{(fmv_pkg::DIV_W - fmv_pkg::PROD_W){1'b0}}, mul_next};
					mcand_q  <= {{(fmv_pkg::PROD_W - fmv_pkg::SUM_W){1'b0}}, abs_sum};
					mplier_q <= abs_sum;
					step_q   <= fmv_pkg::STEP_W'(fmv_pkg::SUM_W - 1);
				end else begin
					// Variance: divide (n*Q - S*S) * 2^F by n*n
					acc_q  <= {mul_next, {fmv_pkg::FRACTION_BITS{1'b0}}};
					rem_q  <= '0;
					step_q <= fmv_pkg::STEP_W'(fmv_pkg::DIV_W - 1);
				end
			end
			ST_DIVV: begin
				acc_q  <= quo_next;
				rem_q  <= rem_next;
				step_q <= step_q - 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					res_q.mean_q8     <= mean_q;
					res_q.variance_q8 <= acc_q[fmv_pkg::VAR_W-1:0];
					res_q.frame_count <= cnt_q;
					res_q.overflow    <= ovf_q;
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_xfer && sample_data.last) |=> sample_stall)
		else $error("block took a sample right after a frame end");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVM || state_q == ST_DIVV) |-> (den_q != '0))
		else $error("divide step with a zero divisor");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVM || state_q == ST_DIVV) |-> (rem_q < den_q))
		else $error("partial remainder not below divisor");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == fmv_pkg::COUNT_MAX) |=> (cnt_q == fmv_pkg::COUNT_MAX || cnt_q == '0))
		else $error("sample count wrapped");
`endif

endmodule

`default_nettype wire

/* test/frame_mean_variance_checker.sv */
`timescale 1ns / 100ps

module frame_mean_variance_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	input  logic             sample_stall,
	input  fmv_pkg::sample_t sample_data,
	input  logic             result_valid,
	input  logic             result_stall,
	input  fmv_pkg::result_t result_data,
	output int               mismatches,
	output int               pending,
	output int               frames_checked,
	output int               samples_taken
);

	// Running frame totals, mirrored from the sample transfers
	logic [fmv_pkg::COUNT_BITS-1:0]   frame_samples;
	logic signed [fmv_pkg::SUM_W-1:0] frame_sum;
	logic [fmv_pkg::SQ_W-1:0]         frame_square_sum;
	logic                             frame_dropped;

	fmv_pkg::result_t   expected_stats[$];
	fmv_pkg::result_t   want;
	logic signed [31:0] value_w;
	int                 error_count  = 0;
	int                 result_count = 0;
	int                 sample_count = 0;
	int                 waiting      = 0;

	assign mismatches     = error_count;
	assign pending        = waiting;
	assign frames_checked = result_count;
	assign samples_taken  = sample_count;

	// Exact floored mean and population variance of one frame
	function automatic fmv_pkg::result_t frame_statistics(
			input logic [fmv_pkg::COUNT_BITS-1:0] count,
			input logic signed [fmv_pkg::SUM_W-1:0] sum,
			input logic [fmv_pkg::SQ_W-1:0] square_sum, input logic dropped);
		logic signed [127:0] n_w;
		logic signed [127:0] s_w;
		logic signed [127:0] q_w;
		logic signed [127:0] scaled_sum;
		logic signed [127:0] mean_w;
		logic signed [127:0] var_w;
		fmv_pkg::result_t    stats;
		n_w        = {{(128 - fmv_pkg::COUNT_BITS){1'b0}}, count};
		s_w        = 128'(sum);
		q_w        = {{(128 - fmv_pkg::SQ_W){1'b0}}, square_sum};
		scaled_sum = s_w <<< fmv_pkg::FRACTION_BITS;
		mean_w     = scaled_sum / n_w;
		// round toward minus infinity, not toward zero
		if (scaled_sum < 0 && (scaled_sum % n_w) != 0) begin
			mean_w = mean_w - 1;
		end
		var_w = ((n_w * q_w - s_w * s_w) <<< fmv_pkg::FRACTION_BITS) / (n_w * n_w);
		stats.mean_q8     = mean_w[fmv_pkg::MEAN_W-1:0];
		stats.variance_q8 = var_w[fmv_pkg::VAR_W-1:0];
		stats.frame_count = count;
		stats.overflow    = dropped;
		return stats;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			error_count++;
			if (error_count <= 10) begin
				$display("%t: result %0d, %s: expected 0x%0h, got 0x%0h", $realtime,
					result_count, field, want_v, got_v);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_samples    = '0;
			frame_sum        = '0;
			frame_square_sum = '0;
			frame_dropped    = 1'b0;
			expected_stats.delete();
			waiting          = 0;
		end else begin
			// compare a result transfer with the oldest prediction
			if (result_valid && !result_stall) begin
				if (expected_stats.size() == 0) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%t: result with no frame pending: mean 0x%0h, var 0x%0h",
							$realtime, result_data.mean_q8, result_data.variance_q8);
					end
				end else begin
					want = expected_stats.pop_front();
					check_field("mean_q8", 64'(want.mean_q8), 64'(result_data.mean_q8));
					check_field("variance_q8", 64'(want.variance_q8),
						64'(result_data.variance_q8));
					check_field("frame_count", 64'(want.frame_count),
						64'(result_data.frame_count));
					check_field("overflow", 64'(want.overflow), 64'(result_data.overflow));
				end
				result_count++;
			end

			// accumulate a sample transfer; drop it once the count is saturated
			if (sample_valid && !sample_stall) begin
				sample_count++;
				value_w = 32'(sample_data.sample);
				if (frame_samples != fmv_pkg::COUNT_MAX) begin
					frame_samples    = frame_samples + 1'b1;
					frame_sum        = frame_sum + value_w;
					frame_square_sum = frame_square_sum + fmv_pkg::SQ_W'(value_w * value_w);
				end else begin
					frame_dropped = 1'b1;
				end
				// predict at frame end and start the next frame clean
				if (sample_data.last) begin
					expected_stats.push_back(frame_statistics(frame_samples, frame_sum,
						frame_square_sum, frame_dropped));
					frame_samples    = '0;
					frame_sum        = '0;
					frame_square_sum = '0;
					frame_dropped    = 1'b0;
				end
			end
			waiting = expected_stats.size();
		end
	end

endmodule

/* test/frame_mean_variance_top_tb.sv */
`timescale 1ns / 100ps

module frame_mean_variance_top_tb;

	typedef enum {SPREAD_UNIFORM, SPREAD_EXTREME, SPREAD_NARROW, SPREAD_FLAT} spread_e;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             sample_valid = 1'b0;
	logic             sample_stall;
	fmv_pkg::sample_t sample_data  = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	fmv_pkg::result_t result_data;

	int mismatches;
	int pending;
	int frames_checked;
	int samples_taken;
	int burst_left   = 0;
	int stall_run    = 0;
	int samples_sent = 0;

	always #1 clk = ~clk;

	frame_mean_variance_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	frame_mean_variance_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample_data    (sample_data),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_data    (result_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.frames_checked (frames_checked),
		.samples_taken  (samples_taken)
	);

	// Stall the result channel in runs of random length, about a third of them stalled
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_run    <= $urandom_range(1, 20);
			result_stall <= ($urandom_range(0, 2) == 0);
		end else begin
			stall_run <= stall_run - 1;
		end
	end

	// Offer one sample and hold it until the transfer; idle between bursts
	task automatic send_sample(input logic signed [15:0] value, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 6);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_valid       <= 1'b1;
		sample_data.sample <= value;
		sample_data.last   <= is_last;
		samples_sent++;
		do @(posedge clk); while (sample_stall);
	endtask

	function automatic logic signed [15:0] pick_value(input spread_e spread,
			input logic signed [15:0] center);
		case (spread)
			SPREAD_UNIFORM: pick_value = 16'($urandom);
			SPREAD_EXTREME: pick_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			SPREAD_NARROW:  pick_value = 16'(int'(center) + int'($urandom_range(0, 15)) - 8);
			default:        pick_value = center;
		endcase
	endfunction

	task automatic send_frame(input int length, input spread_e spread);
		logic signed [15:0] center;
		center = 16'($urandom);
		for (int i = 0; i < length; i++) begin
			send_sample(pick_value(spread, center), i == length - 1);
		end
	endtask

	initial begin
		int      length;
		int      random_start;
		spread_e spread;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// one-sample frames at the extremes: mean is the sample, variance zero
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sd0, 1'b1);
		send_sample(-16'sd1, 1'b1);
		// full-scale swing
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		// negative sum that does not divide evenly
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd0, 1'b1);
		// constant frame
		repeat (3) send_sample(16'sd5, 1'b0);
		send_sample(16'sd5, 1'b1);
		// short ramp whose variance is a whole number
		for (int i = 1; i <= 7; i++) begin
			send_sample(16'(i), i == 7);
		end

		// random frames, mostly short
		random_start = samples_sent;
		while (samples_sent - random_start < 1030) begin
			length = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64)
				: $urandom_range(1, 8);
			spread = spread_e'($urandom_range(0, 3));
			send_frame(length, spread);
		end
		sample_valid <= 1'b0;

		// drain the results, then give stray results time to show up
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);

		$display("Checked %0d frame results from %0d samples: one-sample frames,",
			frames_checked, samples_taken);
		$display("full-scale swings and random frames of up to 64 samples.");
		if (mismatches == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
